// ===== sv/brle_pkg.sv =====
// types and constants shared by the byte run-length decoder
// no dependencies
package brle_pkg;

  localparam int HDR_BYTES = 8;
  localparam int OUT_BYTES = 8;
  localparam int CTRL_RUN_BIT = 7;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_SHORT_HDR = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTROL = 2'd1,
    PH_RUN     = 2'd2,
    PH_LITERAL = 2'd3
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        out_last;
    logic        out_status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
  } brle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic run_start;
    logic run_final;
  } brle_stat_t;

endpackage

// ===== sv/brle_ctrl.sv =====
// controller: idle / run emission state machine and input handshake
// depends on brle_pkg
module brle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brle_pkg::brle_stat_t stat,
  output brle_pkg::brle_cmd_t  cmd
);
  import brle_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready && stat.run_start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!stat.out_busy && stat.run_final) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = !stat.out_busy;
        cmd.accept = in_valid && !stat.out_busy;
      end
      ST_RUN: begin
        cmd.step = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/brle_dp.sv =====
// datapath: header size, block state, run engine and output register
// depends on brle_pkg
module brle_dp #(
  parameter int LANE_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brle_pkg::in_item_t   in_item,
  input  brle_pkg::brle_cmd_t  cmd,
  output brle_pkg::brle_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brle_pkg::out_item_t  out_item
);
  import brle_pkg::*;

  localparam int LANE = (LANE_BYTES > OUT_BYTES) ? OUT_BYTES :
                        ((LANE_BYTES < 1) ? 1 : LANE_BYTES);
  localparam logic [7:0] LANE8 = 8'(LANE);

  // room_r holds declared size minus bytes already emitted
  logic [63:0] room_r, room_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  run_left_r, run_left_nxt;
  logic [7:0]  run_byte_r, run_byte_nxt;
  logic        run_last_r, run_last_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        room_lt;
  logic [7:0]  run_n;
  logic [7:0]  chunk;
  logic        chunk_final;
  logic        emit_lit;
  logic        need_run;
  logic        short_hdr;

  assign room_lt     = (room_r[63:8] == 56'd0) && (room_r[7:0] < rem_r);
  assign run_n       = room_lt ? room_r[7:0] : rem_r;
  assign chunk       = (run_left_r > LANE8) ? LANE8 : run_left_r;
  assign chunk_final = (run_left_r <= LANE8);

  assign stat.out_busy  = out_valid_r && !out_ready;
  assign stat.run_start = (phase_r == PH_RUN) && (run_n != 8'd0);
  assign stat.run_final = chunk_final;

  always_comb begin
    room_nxt      = room_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    run_left_nxt  = run_left_r;
    run_byte_nxt  = run_byte_r;
    run_last_nxt  = run_last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    emit_lit      = 1'b0;
    need_run      = 1'b0;
    short_hdr     = 1'b0;

    if (cmd.accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          room_nxt[8*hdr_cnt_r[2:0] +: 8] = in_item.in_byte;
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_r == 4'(HDR_BYTES - 1)) phase_nxt = PH_CONTROL;
          else short_hdr = 1'b1;
        end
        PH_CONTROL: begin
          // nothing more to produce once the declared size is reached
          if (room_r != 64'd0) begin
            rem_nxt   = {1'b0, in_item.in_byte[6:0]} + 8'd1;
            phase_nxt = in_item.in_byte[CTRL_RUN_BIT] ? PH_RUN : PH_LITERAL;
          end
        end
        PH_RUN: begin
          need_run     = (run_n != 8'd0);
          room_nxt     = room_r - 64'(run_n);
          rem_nxt      = 8'd0;
          phase_nxt    = PH_CONTROL;
          run_left_nxt = run_n;
          run_byte_nxt = in_item.in_byte;
          run_last_nxt = in_item.in_last;
        end
        PH_LITERAL: begin
          if (room_r != 64'd0) begin
            emit_lit = 1'b1;
            room_nxt = room_r - 64'd1;
          end
          if (rem_r != 8'd0) rem_nxt = rem_r - 8'd1;
          if (rem_r <= 8'd1) phase_nxt = PH_CONTROL;
        end
        default: ;
      endcase

      if (emit_lit) begin
        out_nxt.out_data   = {56'd0, in_item.in_byte};
        out_nxt.out_count  = 4'd1;
        out_nxt.out_last   = in_item.in_last;
        out_nxt.out_status = STATUS_OK;
        out_valid_nxt      = 1'b1;
      end else if (in_item.in_last && !need_run) begin
        // end-only item
        out_nxt.out_data   = 64'd0;
        out_nxt.out_count  = 4'd0;
        out_nxt.out_last   = 1'b1;
        out_nxt.out_status = short_hdr ? STATUS_SHORT_HDR : STATUS_OK;
        out_valid_nxt      = 1'b1;
      end

      // buffer end: back to header phase for the next buffer
      if (in_item.in_last) begin
        room_nxt    = 64'd0;
        hdr_cnt_nxt = 4'd0;
        phase_nxt   = PH_HEADER;
        rem_nxt     = 8'd0;
      end
    end

    if (cmd.step) begin
      for (int j = 0; j < OUT_BYTES; j++) begin
        out_nxt.out_data[8*j +: 8] = (8'(j) < chunk) ? run_byte_r : 8'h00;
      end
      out_nxt.out_count  = chunk[3:0];
      out_nxt.out_last   = chunk_final && run_last_r;
      out_nxt.out_status = STATUS_OK;
      out_valid_nxt      = 1'b1;
      run_left_nxt       = run_left_r - chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r      <= 64'd0;
      hdr_cnt_r   <= 4'd0;
      phase_r     <= PH_HEADER;
      rem_r       <= 8'd0;
      run_left_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      room_r      <= room_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    run_last_r <= run_last_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== sv/byte_rle_decoder.sv =====
// Byte run-length decoder with an 8-byte little-endian size header. Header, control
// and literal bytes are taken one per cycle; a literal byte within the declared size
// gives a one-byte item. A run value byte is taken and then holds off input while its
// run of n bytes (cut at the declared size) leaves the output register as ceil(n/lane)
// items, one per cycle that out_ready allows. Lane width is LANE_BYTES clamped to 1..8.
// Every input byte waits while the output register holds an item that out_ready has
// not yet taken.
// depends on brle_pkg, brle_ctrl, brle_dp
module byte_rle_decoder #(
  parameter int LANE_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brle_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output brle_pkg::out_item_t out_item
);
  import brle_pkg::*;

  brle_cmd_t  cmd;
  brle_stat_t stat;

  brle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brle_dp #(
    .LANE_BYTES (LANE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !cmd.accept)
    else $error("run step and input accept in the same cycle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_count == 4'd0) |-> out_item.out_last)
    else $error("empty item not marked last");

  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_status == STATUS_SHORT_HDR) |->
      (out_item.out_count == 4'd0))
    else $error("short header status on a data item");

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (out_valid && out_item.out_count != 4'd0))
    else $error("run step did not load a data item");
`endif

endmodule
